// ----- hdl/epsv_pkg.sv -----
// shared types, constants and helpers of the plucked-string voice
`timescale 1ns / 1ps

package epsv_pkg;

  localparam int MAX_DELAY  = 4096;
  localparam int ADDR_W     = $clog2(MAX_DELAY);
  localparam int CNT_W      = ADDR_W + 1;
  localparam int SAMPLE_W   = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int ACC_W      = 34;
  localparam int MUL_A_W    = 34;
  localparam int MUL_B_W    = 19;
  localparam int PROD_W     = MUL_A_W + MUL_B_W;
  localparam int WIDE_W     = 21;

  localparam logic [CNT_W-1:0] MIN_DELAY_LEN = CNT_W'(2);
  localparam logic [CNT_W-1:0] MAX_DELAY_LEN = CNT_W'(MAX_DELAY);

  // pick filter taps in Q0.16
  localparam logic [MUL_B_W-1:0] PICK_TAP_IN   = MUL_B_W'(6554);
  localparam logic [MUL_B_W-1:0] PICK_TAP_PREV = MUL_B_W'(58982);
  localparam logic [17:0]        ONE_Q17       = 18'h20000;
  // ceil(2^17 / 3), exact quotient for operands below 2^17
  localparam logic [MUL_B_W-1:0] RECIP3        = MUL_B_W'(43691);
  localparam logic [45:0]        CUBE_HALF     = 46'd1610612736;
  localparam logic [PROD_W-1:0]  FB_HALF       = PROD_W'(64'h1_0000_0000);
  localparam logic signed [SAMPLE_W-1:0] CLIP_LEVEL = 16'sd21845;

  // reset values of the registers
  localparam logic [CNT_W-1:0] RST_DELAY_LENGTH = CNT_W'(100);
  localparam logic [15:0]      RST_LOSS         = 16'd65535;
  localparam logic [15:0]      RST_BRIGHT       = 16'd32768;
  localparam logic [15:0]      RST_GAIN         = 16'd4096;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DELAY_LENGTH = 3'd0,
    CFG_PICK_DIR     = 3'd1,
    CFG_PICK_POS     = 3'd2,
    CFG_LOSS         = 3'd3,
    CFG_BRIGHT       = 3'd4,
    CFG_GAIN         = 3'd5
  } cfg_reg_t;

  typedef struct packed {
    logic [CNT_W-1:0] delay_length;
    logic             pick_direction_select;
    logic [CNT_W-1:0] pick_position;
    logic [15:0]      loss_factor;
    logic [15:0]      brightness;
    logic [15:0]      distortion_gain;
  } epsv_cfg_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RD,
    ST_PF2,
    ST_PF3,
    ST_LP2,
    ST_LP3,
    ST_RHO,
    ST_CUB1,
    ST_CUB2,
    ST_DIV3,
    ST_OUT
  } epsv_state_t;

  typedef struct packed {
    epsv_state_t step;
    logic        accept;
    logic        out_load;
  } epsv_ctrl_t;

  function automatic logic signed [SAMPLE_W-1:0] sat16(input logic signed [WIDE_W-1:0] v);
    logic signed [SAMPLE_W-1:0] r;
    if (v > WIDE_W'(32767)) begin
      r = 16'sh7fff;
    end else if (v < -WIDE_W'(32768)) begin
      r = 16'sh8000;
    end else begin
      r = v[SAMPLE_W-1:0];
    end
    return r;
  endfunction

endpackage

// ----- hdl/epsv_ram.sv -----
// generic single-port-write, registered-read memory
`timescale 1ns / 1ps

module epsv_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ----- hdl/epsv_mul.sv -----
// shared signed multiplier with registered product
`timescale 1ns / 1ps

module epsv_mul (
  input  logic                                clk,
  input  logic                                en,
  input  logic signed [epsv_pkg::MUL_A_W-1:0] a,
  input  logic signed [epsv_pkg::MUL_B_W-1:0] b,
  output logic signed [epsv_pkg::PROD_W-1:0]  prod
);

  always_ff @(posedge clk) begin
    if (en) begin
      prod <= a * b;
    end
  end

endmodule

// ----- hdl/epsv_ctrl.sv -----
// per-item sequencer of the plucked-string voice
`timescale 1ns / 1ps

module epsv_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  logic                 out_busy,
  output logic                 in_stall,
  output epsv_pkg::epsv_ctrl_t ctrl
);

  epsv_pkg::epsv_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= epsv_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      epsv_pkg::ST_IDLE: if (in_valid) state_next = epsv_pkg::ST_RD;
      epsv_pkg::ST_RD:   state_next = epsv_pkg::ST_PF2;
      epsv_pkg::ST_PF2:  state_next = epsv_pkg::ST_PF3;
      epsv_pkg::ST_PF3:  state_next = epsv_pkg::ST_LP2;
      epsv_pkg::ST_LP2:  state_next = epsv_pkg::ST_LP3;
      epsv_pkg::ST_LP3:  state_next = epsv_pkg::ST_RHO;
      epsv_pkg::ST_RHO:  state_next = epsv_pkg::ST_CUB1;
      epsv_pkg::ST_CUB1: state_next = epsv_pkg::ST_CUB2;
      epsv_pkg::ST_CUB2: state_next = epsv_pkg::ST_DIV3;
      epsv_pkg::ST_DIV3: state_next = epsv_pkg::ST_OUT;
      epsv_pkg::ST_OUT:  if (!out_busy) state_next = epsv_pkg::ST_IDLE;
      default:           state_next = epsv_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall      = (state != epsv_pkg::ST_IDLE);
    ctrl.step     = state;
    ctrl.accept   = (state == epsv_pkg::ST_IDLE) && in_valid;
    ctrl.out_load = (state == epsv_pkg::ST_OUT) && !out_busy;
  end

endmodule

// ----- hdl/epsv_core.sv -----
// string loop datapath: delay line, excitation history, filters and soft clip
`timescale 1ns / 1ps

module epsv_core (
  input  logic                                 clk,
  input  logic                                 rst,
  input  epsv_pkg::epsv_ctrl_t                 ctrl,
  input  epsv_pkg::epsv_cfg_t                  cfg,
  input  logic                                 start_note,
  input  logic signed [epsv_pkg::SAMPLE_W-1:0] excitation_sample,
  output logic signed [epsv_pkg::SAMPLE_W-1:0] result
);

  localparam int AW = epsv_pkg::ADDR_W;
  localparam int CW = epsv_pkg::CNT_W;
  localparam int SW = epsv_pkg::SAMPLE_W;
  localparam int WW = epsv_pkg::WIDE_W;

  // note state
  logic [CW-1:0]        dl;
  logic [AW-1:0]        wptr;
  logic [CW-1:0]        wptr_inc;
  logic [CW-1:0]        fill;
  logic [CW-1:0]        counter;
  logic signed [SW-1:0] pf_prev;
  logic signed [SW-1:0] lp_prev;
  logic signed [SW-1:0] fb;

  // per-item working registers
  logic signed [SW-1:0]                x_r;
  logic signed [SW-1:0]                d_r;
  logic signed [SW-1:0]                h_r;
  logic signed [SW-1:0]                pf_r;
  logic signed [SW-1:0]                din_r;
  logic signed [epsv_pkg::ACC_W-1:0]   acc;
  logic signed [WW-1:0]                xq;

  logic                                excite;
  logic                                comb_on;
  logic [CW-1:0]                       hist_diff;
  logic [AW-1:0]                       hist_rd_addr;
  logic [SW-1:0]                       dly_rdata;
  logic [SW-1:0]                       hist_rdata;

  logic                                mul_en;
  logic signed [epsv_pkg::MUL_A_W-1:0] mul_a;
  logic signed [epsv_pkg::MUL_B_W-1:0] mul_b;
  logic signed [epsv_pkg::PROD_W-1:0]  prod;
  logic signed [epsv_pkg::ACC_W-1:0]   prod_lo;

  logic signed [epsv_pkg::ACC_W-1:0]   pf_sum;
  logic signed [epsv_pkg::ACC_W-1:0]   pf_sh;
  logic signed [SW-1:0]                pf_calc;
  logic signed [SW-1:0]                comb_src;
  logic signed [SW:0]                  comb;
  logic signed [SW+1:0]                din_sum;
  logic signed [SW-1:0]                din_calc;
  logic signed [epsv_pkg::PROD_W-1:0]  fb_sh;
  logic signed [SW-1:0]                fb_calc;
  logic signed [32:0]                  gp;
  logic signed [32:0]                  xq_sh;
  logic signed [WW-1:0]                xq_neg;
  logic [WW-1:0]                       xq_abs;
  logic [14:0]                         mag;
  logic [45:0]                         cube_rnd;
  logic [15:0]                         quot;
  logic [14:0]                         t;
  logic signed [WW-1:0]                y_w;
  logic                                clip_hi;
  logic                                clip_lo;
  logic [17:0]                         b0;

  always_comb begin
    if (cfg.delay_length < epsv_pkg::MIN_DELAY_LEN) begin
      dl = epsv_pkg::MIN_DELAY_LEN;
    end else if (cfg.delay_length > epsv_pkg::MAX_DELAY_LEN) begin
      dl = epsv_pkg::MAX_DELAY_LEN;
    end else begin
      dl = cfg.delay_length;
    end
  end

  assign wptr_inc     = {1'b0, wptr} + CW'(1);
  assign excite       = counter < dl;
  assign comb_on      = counter > cfg.pick_position;
  assign hist_diff    = counter - cfg.pick_position;
  assign hist_rd_addr = hist_diff[AW-1:0];
  assign b0           = epsv_pkg::ONE_Q17 - {2'b00, cfg.brightness};

  epsv_ram #(.WIDTH(SW), .DEPTH(epsv_pkg::MAX_DELAY)) u_delay (
    .clk     (clk),
    .wr_en   (ctrl.step == epsv_pkg::ST_LP3),
    .wr_addr (wptr),
    .wr_data (din_r),
    .rd_en   (ctrl.step == epsv_pkg::ST_RD),
    .rd_addr (wptr),
    .rd_data (dly_rdata)
  );

  epsv_ram #(.WIDTH(SW), .DEPTH(epsv_pkg::MAX_DELAY)) u_hist (
    .clk     (clk),
    .wr_en   ((ctrl.step == epsv_pkg::ST_LP2) && excite),
    .wr_addr (counter[AW-1:0]),
    .wr_data (pf_r),
    .rd_en   (ctrl.step == epsv_pkg::ST_RD),
    .rd_addr (hist_rd_addr),
    .rd_data (hist_rdata)
  );

  // operand selection for the shared multiplier
  always_comb begin
    mul_en = 1'b1;
    mul_a  = '0;
    mul_b  = '0;
    unique case (ctrl.step)
      epsv_pkg::ST_RD: begin
        mul_a = epsv_pkg::MUL_A_W'(x_r);
        mul_b = epsv_pkg::PICK_TAP_IN;
      end
      epsv_pkg::ST_PF2: begin
        mul_a = epsv_pkg::MUL_A_W'(pf_prev);
        mul_b = epsv_pkg::PICK_TAP_PREV;
      end
      epsv_pkg::ST_PF3: begin
        mul_a = epsv_pkg::MUL_A_W'(d_r);
        mul_b = {1'b0, b0};
      end
      epsv_pkg::ST_LP2: begin
        mul_a = epsv_pkg::MUL_A_W'(lp_prev);
        mul_b = {3'b000, cfg.brightness};
      end
      epsv_pkg::ST_LP3: begin
        mul_a = epsv_pkg::MUL_A_W'(d_r);
        mul_b = {3'b000, cfg.distortion_gain};
      end
      epsv_pkg::ST_RHO: begin
        mul_a = acc;
        mul_b = {3'b000, cfg.loss_factor};
      end
      epsv_pkg::ST_CUB1: begin
        mul_a = {19'd0, mag};
        mul_b = {4'd0, mag};
      end
      epsv_pkg::ST_CUB2: begin
        mul_a = {4'd0, prod[29:0]};
        mul_b = {4'd0, mag};
      end
      epsv_pkg::ST_DIV3: begin
        mul_a = {18'd0, quot};
        mul_b = epsv_pkg::RECIP3;
      end
      default: mul_en = 1'b0;
    endcase
  end

  epsv_mul u_mul (
    .clk  (clk),
    .en   (mul_en),
    .a    (mul_a),
    .b    (mul_b),
    .prod (prod)
  );

  assign prod_lo = prod[epsv_pkg::ACC_W-1:0];

  // pick filter, rounding half up at bit 16
  always_comb begin
    pf_sum  = acc + prod_lo;
    pf_sh   = (pf_sum + epsv_pkg::ACC_W'(32768)) >>> 16;
    pf_calc = epsv_pkg::sat16(pf_sh[WW-1:0]);
  end

  // pick-position comb; a zero offset reads back the sample just written
  always_comb begin
    comb_src = (hist_rd_addr == counter[AW-1:0]) ? pf_r : h_r;
    if (comb_on) begin
      comb = (SW+1)'(pf_r) - (SW+1)'(comb_src);
    end else begin
      comb = (SW+1)'(pf_r);
    end
    din_sum  = (SW+2)'(comb) + (SW+2)'(fb);
    din_calc = excite ? epsv_pkg::sat16(WW'(din_sum)) : fb;
  end

  // loop feedback: lowpass sum times loss, rounded at bit 33
  always_comb begin
    fb_sh   = (prod + $signed(epsv_pkg::FB_HALF)) >>> 33;
    fb_calc = epsv_pkg::sat16(fb_sh[WW-1:0]);
  end

  // drive gain and cubic soft clip
  always_comb begin
    gp       = prod[32:0];
    xq_sh    = (gp + 33'sd2048) >>> 12;
    xq_neg   = -xq;
    xq_abs   = xq[WW-1] ? xq_neg : xq;
    mag      = xq_abs[14:0];
    cube_rnd = prod[45:0] + epsv_pkg::CUBE_HALF;
    quot     = cube_rnd[45:30];
    t        = prod[31:17];
    clip_hi  = xq >= WW'(32768);
    clip_lo  = xq <= -WW'(32768);
    y_w      = xq[WW-1] ? (xq + WW'(t)) : (xq - WW'(t));
    if (clip_hi) begin
      result = epsv_pkg::CLIP_LEVEL;
    end else if (clip_lo) begin
      result = -epsv_pkg::CLIP_LEVEL;
    end else begin
      result = y_w[SW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      counter <= '0;
      wptr    <= '0;
      fill    <= '0;
      pf_prev <= '0;
      lp_prev <= '0;
      fb      <= '0;
    end else begin
      if (ctrl.accept) begin
        if (start_note) begin
          counter <= '0;
          wptr    <= '0;
          fill    <= '0;
          pf_prev <= '0;
          lp_prev <= '0;
          fb      <= '0;
        end else if ({1'b0, wptr} >= dl) begin
          wptr <= '0;
        end
      end
      if ((ctrl.step == epsv_pkg::ST_LP2) && excite) begin
        pf_prev <= pf_r;
      end
      if (ctrl.step == epsv_pkg::ST_LP3) begin
        wptr <= (wptr_inc >= dl) ? '0 : wptr_inc[AW-1:0];
        // delay line entries at or above the fill mark still read as zero
        if (wptr_inc > fill) begin
          fill <= wptr_inc;
        end
        if (excite) begin
          counter <= counter + CW'(1);
        end
      end
      if (ctrl.step == epsv_pkg::ST_CUB1) begin
        fb      <= fb_calc;
        lp_prev <= d_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.accept) begin
      x_r <= excitation_sample;
    end
    unique case (ctrl.step)
      epsv_pkg::ST_PF2: begin
        d_r <= ({1'b0, wptr} < fill) ? $signed(dly_rdata) : '0;
        h_r <= $signed(hist_rdata);
        acc <= prod_lo;
      end
      epsv_pkg::ST_PF3: begin
        pf_r <= cfg.pick_direction_select ? pf_calc : x_r;
      end
      epsv_pkg::ST_LP2: begin
        acc   <= prod_lo;
        din_r <= din_calc;
      end
      epsv_pkg::ST_LP3: begin
        acc <= acc + prod_lo;
      end
      epsv_pkg::ST_RHO: begin
        xq <= xq_sh[WW-1:0];
      end
      default: ;
    endcase
  end

endmodule

// ----- hdl/extended_plucked_string_voice.sv -----
// top level of the plucked-string voice: config registers, sequencer, datapath, output register
// state OUT loads the result into the output register and waits while the register is held
// a new item is accepted only back in idle, after OUT; nine products share one multiplier
// a finished result waits in the output register while the next item is accepted
// reset clears the registers to their defaults and all note state; no clearing pass,
// the delay line reads zero above a fill mark that reset and start_note clear
`timescale 1ns / 1ps

module extended_plucked_string_voice (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic                                   start_note,
  input  logic signed [epsv_pkg::SAMPLE_W-1:0]   excitation_sample,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic signed [epsv_pkg::SAMPLE_W-1:0]   voice_sample,
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [epsv_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [epsv_pkg::CFG_DATA_W-1:0]        cfg_data
);

  epsv_pkg::epsv_cfg_t                  cfg;
  epsv_pkg::epsv_ctrl_t                 ctrl;
  logic                                 out_busy;
  logic signed [epsv_pkg::SAMPLE_W-1:0] result;

  assign cfg_ready = 1'b1;
  assign out_busy  = out_valid && out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.delay_length          <= epsv_pkg::RST_DELAY_LENGTH;
      cfg.pick_direction_select <= 1'b0;
      cfg.pick_position         <= '0;
      cfg.loss_factor           <= epsv_pkg::RST_LOSS;
      cfg.brightness            <= epsv_pkg::RST_BRIGHT;
      cfg.distortion_gain       <= epsv_pkg::RST_GAIN;
    end else if (cfg_valid && cfg_ready) begin
      unique case (epsv_pkg::cfg_reg_t'(cfg_index))
        epsv_pkg::CFG_DELAY_LENGTH: cfg.delay_length <= cfg_data[epsv_pkg::CNT_W-1:0];
        epsv_pkg::CFG_PICK_DIR:     cfg.pick_direction_select <= cfg_data[0];
        epsv_pkg::CFG_PICK_POS:     cfg.pick_position <= cfg_data[epsv_pkg::CNT_W-1:0];
        epsv_pkg::CFG_LOSS:         cfg.loss_factor <= cfg_data;
        epsv_pkg::CFG_BRIGHT:       cfg.brightness <= cfg_data;
        epsv_pkg::CFG_GAIN:         cfg.distortion_gain <= cfg_data;
        default: ;
      endcase
    end
  end

  epsv_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .out_busy (out_busy),
    .in_stall (in_stall),
    .ctrl     (ctrl)
  );

  epsv_core u_core (
    .clk               (clk),
    .rst               (rst),
    .ctrl              (ctrl),
    .cfg               (cfg),
    .start_note        (start_note),
    .excitation_sample (excitation_sample),
    .result            (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctrl.out_load) begin
      out_valid <= 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.out_load) begin
      voice_sample <= result;
    end
  end

endmodule

// ----- hdl/epsv_checker.sv -----
// port-level checks of the plucked-string voice and their binding
`timescale 1ns / 1ps

module epsv_checker (
  input logic                                 clk,
  input logic                                 rst,
  input logic                                 in_valid,
  input logic                                 in_stall,
  input logic                                 out_valid,
  input logic                                 out_stall,
  input logic signed [epsv_pkg::SAMPLE_W-1:0] voice_sample
);

  // a held result keeps its value
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(voice_sample))
    else $error("held output item changed");

  // soft clip never exceeds two thirds of full scale
  a_out_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (voice_sample <= epsv_pkg::CLIP_LEVEL) &&
                  (voice_sample >= -epsv_pkg::CLIP_LEVEL))
    else $error("output sample beyond clip level");

  // one item at a time: input closes right after an accept
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("second item accepted while busy");

  // no result appears in the cycle after an accept
  a_no_early_result: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && !out_valid |=> !out_valid)
    else $error("result appeared too early");

endmodule

bind extended_plucked_string_voice epsv_checker u_epsv_checker (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (in_valid),
  .in_stall     (in_stall),
  .out_valid    (out_valid),
  .out_stall    (out_stall),
  .voice_sample (voice_sample)
);

// ----- verif/testbench.sv -----
// testbench of the plucked-string voice: scoreboard prediction, random notes and stalls
`timescale 1ns / 1ps

module testbench;
  import epsv_pkg::*;

  localparam longint TAP_NEW    = 6554;
  localparam longint TAP_OLD    = 58982;
  localparam longint CLIP_MAG   = 21845;
  localparam longint CUBE_DIV   = 64'sd3221225472;
  localparam int     QUIET_LIMIT = 3000;
  localparam int     HOLD_CYCLES = 400;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;

  typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} stall_mode_t;

  class pluck_scoreboard;
    int unsigned loop_len_reg, pick_pos_reg, loss_reg, bright_reg, gain_reg;
    bit pick_dir_reg;
    longint string_line [MAX_DELAY];
    longint pick_history [MAX_DELAY];
    int unsigned wr_ptr, note_count;
    longint pick_prev, lp_prev, feedback;
    logic signed [SAMPLE_W-1:0] expected_voice [$];
    int failures, reported, results_seen;

    function new();
      loop_len_reg = 100;
      pick_dir_reg = 1'b0;
      pick_pos_reg = 0;
      loss_reg = 65535;
      bright_reg = 32768;
      gain_reg = 4096;
      foreach (pick_history[i]) pick_history[i] = 0;
      clear_note();
    endfunction

    function void clear_note();
      foreach (string_line[i]) string_line[i] = 0;
      wr_ptr = 0;
      note_count = 0;
      pick_prev = 0;
      lp_prev = 0;
      feedback = 0;
    endfunction

    function longint clamp_sample(longint v);
      if (v > 32767) return 32767;
      if (v < -32768) return -32768;
      return v;
    endfunction

    // floor of v / 2^s + 1/2
    function longint round_shift(longint v, int s);
      return (v + (64'sd1 <<< (s - 1))) >>> s;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_DELAY_LENGTH: loop_len_reg = data[12:0];
        CFG_PICK_DIR:     pick_dir_reg = data[0];
        CFG_PICK_POS:     pick_pos_reg = data[12:0];
        CFG_LOSS:         loss_reg = data;
        CFG_BRIGHT:       bright_reg = data;
        CFG_GAIN:         gain_reg = data;
        default: ;
      endcase
    endfunction

    function logic signed [SAMPLE_W-1:0] pluck_step(logic start, logic signed [SAMPLE_W-1:0] exc);
      longint x, pf, comb, din, d, acc, xq, cube, quot, y;
      int unsigned dl;
      x = exc;
      if (start) clear_note();
      dl = loop_len_reg;
      if (dl < 2) dl = 2;
      if (dl > MAX_DELAY) dl = MAX_DELAY;
      if (wr_ptr >= dl) wr_ptr = 0;
      if (note_count < dl) begin
        if (pick_dir_reg) pf = clamp_sample(round_shift(x * TAP_NEW + pick_prev * TAP_OLD, 16));
        else pf = x;
        pick_prev = pf;
        pick_history[note_count % MAX_DELAY] = pf;
        if (note_count <= pick_pos_reg) comb = pf;
        else comb = pf - pick_history[(note_count - pick_pos_reg) % MAX_DELAY];
        din = clamp_sample(comb + feedback);
        note_count++;
      end else begin
        din = feedback;
      end
      d = string_line[wr_ptr];
      string_line[wr_ptr] = din;
      wr_ptr++;
      if (wr_ptr >= dl) wr_ptr = 0;
      // two-tap lowpass in Q0.17 scaled by rho
      acc = (131072 - longint'(bright_reg)) * d + longint'(bright_reg) * lp_prev;
      feedback = clamp_sample(round_shift(acc * longint'(loss_reg), 33));
      lp_prev = d;
      xq = round_shift(d * longint'(gain_reg), 12);
      if (xq >= 32768) begin
        y = CLIP_MAG;
      end else if (xq <= -32768) begin
        y = -CLIP_MAG;
      end else begin
        cube = xq * xq * xq;
        quot = (cube >= 0) ? (cube + CUBE_DIV / 2) / CUBE_DIV : -((-cube + CUBE_DIV / 2) / CUBE_DIV);
        y = xq - quot;
      end
      return SAMPLE_W'(y);
    endfunction

    function void note_excitation(logic start, logic signed [SAMPLE_W-1:0] exc);
      expected_voice.push_back(pluck_step(start, exc));
    endfunction

    function void check_voice(logic signed [SAMPLE_W-1:0] actual);
      logic signed [SAMPLE_W-1:0] want;
      results_seen++;
      if (expected_voice.size() == 0) begin
        failures++;
        if (reported < 10) begin
          reported++;
          $display("voice_sample %0d arrived with no item outstanding", actual);
        end
      end else begin
        want = expected_voice.pop_front();
        if (actual !== want) begin
          failures++;
          if (reported < 10) begin
            reported++;
            $display("voice_sample mismatch at result %0d: expected %0d, got %0d",
                     results_seen, want, actual);
          end
        end
      end
    endfunction

    function int pending();
      return expected_voice.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic start_note = 1'b0;
  logic signed [SAMPLE_W-1:0] excitation_sample = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [SAMPLE_W-1:0] voice_sample;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  pluck_scoreboard voice_sb;
  int items_in = 0;
  int cfg_writes = 0;
  int notes_started = 0;
  int note_left = 0;
  int quiet_cycles = 0;
  bit long_hold_done = 1'b0;

  extended_plucked_string_voice i_dut (
    .clk               (clk),
    .rst               (rst),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .start_note        (start_note),
    .excitation_sample (excitation_sample),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .voice_sample      (voice_sample),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && !in_stall) begin
        voice_sb.note_excitation(start_note, excitation_sample);
        items_in++;
      end
      if (out_valid && !out_stall) voice_sb.check_voice(voice_sample);
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QUIET_LIMIT) begin
      $display("no handshake for %0d cycles, %0d results outstanding",
               QUIET_LIMIT, voice_sb.pending());
      $display("DONE: errors detected");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // receiver: stall patterns in chunks, one long hold-off once the run is under way
  initial begin : receiver
    stall_mode_t mode;
    int period, duty, n;
    while (rst) @(posedge clk);
    forever begin
      if (!long_hold_done && items_in >= 500) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        long_hold_done = 1'b1;
      end else begin
        mode = stall_mode_t'($urandom_range(0, 3));
        period = $urandom_range(2, 13);
        duty = $urandom_range(1, period - 1);
        for (n = 0; n < 48; n++) begin
          case (mode)
            STALL_NONE:  out_stall <= 1'b0;
            STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
            STALL_HEAVY: out_stall <= ($urandom_range(0, 4) < 3);
            default:     out_stall <= ((n % period) < duty);
          endcase
          @(posedge clk);
        end
      end
    end
  end

  task automatic offer_item(input logic start, input logic signed [SAMPLE_W-1:0] sample,
                            input int gap);
    in_valid <= 1'b1;
    start_note <= start;
    excitation_sample <= sample;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // the extra edge lets the last accepted item reach the scoreboard first
  task automatic wait_idle();
    in_valid <= 1'b0;
    do @(posedge clk); while (voice_sb.pending() != 0);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    voice_sb.set_reg(idx, data);
    cfg_writes++;
  endtask

  task automatic write_all(input logic [15:0] dly_word, input logic dir,
                           input logic [15:0] pos_word, loss_word, bright_word, gain_word);
    write_reg($urandom_range(0, 1) ? CFG_SPARE_LO : CFG_SPARE_HI, 16'($urandom));
    write_reg(CFG_DELAY_LENGTH, dly_word);
    write_reg(CFG_PICK_DIR, {15'($urandom), dir});
    write_reg(CFG_PICK_POS, pos_word);
    write_reg(CFG_LOSS, loss_word);
    write_reg(CFG_BRIGHT, bright_word);
    write_reg(CFG_GAIN, gain_word);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic signed [SAMPLE_W-1:0] pick_excitation();
    case ($urandom_range(0, 9))
      0: return 16'sh7fff;
      1: return 16'sh8000;
      2: return SAMPLE_W'($signed($urandom_range(0, 511)) - 256);
      default: return SAMPLE_W'($urandom);
    endcase
  endfunction

  task automatic run_phase(input logic [15:0] dly_word, input logic dir,
                           input logic [15:0] pos_word, loss_word, bright_word, gain_word,
                           input int n_items, note_min, note_max);
    int k, burst, gap;
    bit steady, begin_note;
    wait_idle();
    write_all(dly_word, dir, pos_word, loss_word, bright_word, gain_word);
    steady = ($urandom_range(0, 3) == 0);
    burst = $urandom_range(1, 40);
    for (k = 0; k < n_items; k++) begin
      if (note_left == 0) begin
        begin_note = 1'b1;
        note_left = $urandom_range(note_min, note_max);
      end else begin
        // a stray restart in the middle of a note
        begin_note = ($urandom_range(0, 39) == 0);
      end
      if (begin_note) notes_started++;
      note_left--;
      burst--;
      gap = 0;
      if (burst == 0) begin
        burst = $urandom_range(1, 40);
        if (!steady) gap = $urandom_range(1, 14);
      end
      offer_item(begin_note, pick_excitation(), gap);
    end
  endtask

  initial begin : stimulus
    logic probe_start [24];
    logic signed [SAMPLE_W-1:0] probe_value [24];
    int k;
    voice_sb = new();
    probe_start = '{1, 0, 0, 0, 1, 0, 0, 0, 0, 0, 0, 0,
                    0, 0, 0, 0, 0, 0, 1, 0, 0, 0, 0, 0};
    probe_value = '{16'sh7fff, 16'sh8000, -16'sd1, 16'sd1,
                    16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000, -16'sd1, 16'sd1, 16'sd0,
                    16'sh8000, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0,
                    16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000};
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // directed: a few items on the reset settings, then a short loop at full drive
    for (k = 0; k < 24; k++) begin
      if (k == 4) begin
        wait_idle();
        write_all(16'd8, 1'b1, 16'd3, 16'hffff, 16'hffff, 16'hffff);
      end
      if (probe_start[k]) notes_started++;
      offer_item(probe_start[k], probe_value[k], $urandom_range(0, 3));
    end

    run_phase(16'd100,   1'b0, 16'd0,    16'd65535, 16'd32768, 16'd4096,  140, 110, 140);
    run_phase(16'd0,     1'b1, 16'd0,    16'd65535, 16'd0,     16'hffff,  150, 5, 40);
    run_phase(16'd1,     1'b0, 16'hffff, 16'd0,     16'hffff,  16'd0,     100, 3, 30);
    run_phase(16'd16,    1'b1, 16'd5,    16'd60000, 16'd40000, 16'd8192,  200, 20, 80);
    run_phase(16'd37,    1'b0, 16'd12,   16'd65000, 16'd20000, 16'd16384, 200, 40, 120);
    run_phase(16'd4096,  1'b1, 16'd4096, 16'hffff,  16'hffff,  16'd4096,  120, 120, 120);
    run_phase(16'h1fff,  1'b0, 16'd1000, 16'd50000, 16'd100,   16'hffff,  100, 100, 100);
    // upper data bits above the register width are dropped
    run_phase(16'h2005,  1'b1, 16'd2,    16'hffff,  16'hffff,  16'hffff,  150, 10, 60);
    run_phase(16'd64,    1'b1, 16'd32,   16'hffff,  16'd1,     16'd30000, 200, 70, 150);
    run_phase(16'd23,    1'b0, 16'd23,   16'd45000, 16'd32768, 16'd4096,  150, 30, 90);
    run_phase(16'd300,   1'b1, 16'd75,   16'd65300, 16'd24000, 16'd12000, 350, 345, 350);

    wait_idle();
    repeat (16) @(posedge clk);
    voice_sb.failures += voice_sb.pending();
    $display("run covered %0d items in %0d notes, %0d results, %0d register writes",
             items_in, notes_started, voice_sb.results_seen, cfg_writes);
    $display("long receiver hold-off done: %0d, failures counted: %0d",
             long_hold_done, voice_sb.failures);
    if (voice_sb.failures == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
